/* design/coo2csc_pkg.sv */
package coo2csc_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 65536;
  localparam int unsigned WEIGHT_BITS  = 32;

  localparam int unsigned VTX_W  = 10;   // vertex number
  localparam int unsigned IDX_W  = 11;   // 0 .. MAX_VERTICES
  localparam int unsigned CNT_W  = 17;   // 0 .. MAX_EDGES
  localparam int unsigned SLOT_W = 16;

  localparam logic [CNT_W-1:0] EDGE_LIMIT = CNT_W'(MAX_EDGES);
  localparam logic [IDX_W-1:0] VTX_LIMIT  = IDX_W'(MAX_VERTICES);
  localparam logic [IDX_W-1:0] LAST_VTX   = IDX_W'(MAX_VERTICES - 1);

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_COUNT = 3'd1,
    MODE_BUILD = 3'd2,
    MODE_PLACE = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_TOTAL  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT_WR,
    ST_PLACE_WR,
    ST_BUILD_RD,
    ST_BUILD_WR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;       // latch item, read its entries
    logic idx_clr;
    logic idx_inc;
    logic wr_clear;   // zero entry idx of both stores
    logic wr_count;
    logic wr_place;
    logic rd_build;
    logic wr_build;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic count_fail;
    logic place_fail;
    logic clear_last;
    logic build_last;
    logic out_busy;
  } status_t;

endpackage

/* design/coo2csc_ctrl.sv */
module coo2csc_ctrl
  import coo2csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [2:0]  mode,
  input  status_t     status,
  output logic        in_stall,
  output cmd_t        cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.wr_clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (mode)
            MODE_CLEAR: begin
              cmd.idx_clr = 1'b1;
              state_next  = ST_CLEAR;
            end
            MODE_COUNT: state_next = ST_COUNT_WR;
            MODE_BUILD: begin
              cmd.idx_clr = 1'b1;
              state_next  = ST_BUILD_RD;
            end
            MODE_PLACE: state_next = ST_PLACE_WR;
            MODE_READ:  state_next = ST_EMIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_COUNT_WR: begin
        if (status.count_fail) begin
          state_next = ST_EMIT;
        end else begin
          cmd.wr_count = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_PLACE_WR: begin
        cmd.wr_place = !status.place_fail;
        state_next   = ST_EMIT;
      end
      ST_BUILD_RD: begin
        cmd.rd_build = 1'b1;
        state_next   = ST_BUILD_WR;
      end
      ST_BUILD_WR: begin
        cmd.wr_build = 1'b1;
        if (status.build_last) begin
          state_next = ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_BUILD_RD;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/coo2csc_dp.sv */
module coo2csc_dp
  import coo2csc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [IDX_W-1:0]       vertex_count,
  input  logic [2:0]             mode,
  input  logic [VTX_W-1:0]       src_vertex,
  input  logic [VTX_W-1:0]       dst_vertex,
  input  logic [WEIGHT_BITS-1:0] edge_weight,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [SLOT_W-1:0]      slot,
  output logic [VTX_W-1:0]       row_index,
  output logic [WEIGHT_BITS-1:0] weight_out,
  output logic [CNT_W-1:0]       offset_value,
  output logic                   error
);

  logic [CNT_W-1:0] offs_mem [0:MAX_VERTICES];
  logic [CNT_W-1:0] cur_mem  [0:MAX_VERTICES-1];

  logic [2:0]             item_mode;
  logic [VTX_W-1:0]       item_src;
  logic [VTX_W-1:0]       item_dst;
  logic [WEIGHT_BITS-1:0] item_weight;

  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] tally;
  logic [CNT_W-1:0] acc;
  logic [CNT_W-1:0] rd_a;
  logic [CNT_W-1:0] rd_b;
  logic [CNT_W-1:0] rd_c;

  logic [IDX_W-1:0] used_v;
  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [VTX_W-1:0] addr_c;
  logic             rd_en;
  logic [IDX_W-1:0] item_dst_w;
  logic [IDX_W-1:0] item_dst_p1;
  logic             dst_bad;
  logic [CNT_W:0]   slot_sum;
  logic [CNT_W:0]   build_sum;
  logic [CNT_W-1:0] build_val;
  logic             idx_in_use;

  assign used_v      = (vertex_count > VTX_LIMIT) ? VTX_LIMIT : vertex_count;
  assign item_dst_w  = {1'b0, item_dst};
  assign item_dst_p1 = item_dst_w + IDX_W'(1);
  assign dst_bad     = item_dst_w >= used_v;
  assign slot_sum    = {1'b0, rd_a} + {1'b0, rd_c};
  assign build_sum   = {1'b0, acc} + {1'b0, rd_b};
  assign build_val   = (build_sum >= {1'b0, EDGE_LIMIT}) ? EDGE_LIMIT : build_sum[CNT_W-1:0];
  assign idx_in_use  = idx < used_v;

  assign status.count_fail = dst_bad || (tally >= EDGE_LIMIT);
  assign status.place_fail = dst_bad || (slot_sum >= {1'b0, rd_b})
                             || (slot_sum >= {1'b0, EDGE_LIMIT});
  assign status.clear_last = (idx == VTX_LIMIT);
  assign status.build_last = (idx == LAST_VTX);
  assign status.out_busy   = out_valid && out_stall;

  // read addresses come from the ports in the accept cycle; a build read takes addr_b from idx
  assign rd_en  = cmd.take || cmd.rd_build;
  assign addr_a = {1'b0, dst_vertex};
  assign addr_b = cmd.rd_build ? (idx + IDX_W'(1)) : ({1'b0, dst_vertex} + IDX_W'(1));
  assign addr_c = dst_vertex;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_mode   <= mode;
      item_src    <= src_vertex;
      item_dst    <= dst_vertex;
      item_weight <= edge_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= offs_mem[addr_a];
      rd_b <= offs_mem[addr_b];
      rd_c <= cur_mem[addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_clear) begin
      offs_mem[idx] <= '0;
    end else if (cmd.wr_count) begin
      offs_mem[item_dst_p1] <= rd_b + CNT_W'(1);
    end else if (cmd.wr_build && idx_in_use) begin
      offs_mem[idx + IDX_W'(1)] <= build_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_clear && !idx[IDX_W-1]) begin
      cur_mem[idx[VTX_W-1:0]] <= '0;
    end else if (cmd.wr_build) begin
      cur_mem[idx[VTX_W-1:0]] <= '0;
    end else if (cmd.wr_place) begin
      cur_mem[item_dst] <= rd_c + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      tally <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.wr_clear) begin
        tally <= '0;
      end else if (cmd.wr_count) begin
        tally <= tally + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      acc <= '0;
    end else if (cmd.wr_build && idx_in_use) begin
      acc <= build_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      slot         <= '0;
      row_index    <= '0;
      weight_out   <= '0;
      offset_value <= '0;
      error        <= 1'b0;
      unique case (item_mode)
        MODE_BUILD: begin
          result_kind  <= KIND_TOTAL;
          offset_value <= acc;
        end
        MODE_READ: begin
          result_kind <= KIND_OFFSET;
          if (item_dst_w > used_v) begin
            error <= 1'b1;
          end else begin
            offset_value <= rd_a;
          end
        end
        MODE_PLACE: begin
          result_kind <= KIND_EDGE;
          if (status.place_fail) begin
            error <= 1'b1;
          end else begin
            slot       <= slot_sum[SLOT_W-1:0];
            row_index  <= item_src;
            weight_out <= item_weight;
          end
        end
        default: begin
          // failed count
          result_kind <= KIND_EDGE;
          error       <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* design/coo_to_csc_converter.sv */
// COO to CSC converter by counting sort on the destination vertex.
// Input channel (in_valid / in_stall) carries one command item: mode, src_vertex,
// dst_vertex, edge_weight. Output channel (out_valid / out_stall) carries
// result_kind, slot, row_index, weight_out, offset_value and error.
// vertex_count is written on its own channel (cfg_valid / cfg_ready); the user
// must write it only while idle, as the block does not enforce this.
// A failing count reports a result. Clear zeroes one offset entry per cycle;
// build reads and then writes each offset entry in turn.
// A result enters the output register at the end of its item and waits
// there; the block takes the next item while it waits. A new result is held
// back while the previous one is still stalled.
// Clear and a successful count give no result.
// Reset runs a clearing pass over both stores; in_stall stays high until it
// ends. vertex_count resets to 1024.
module coo_to_csc_converter
  import coo2csc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IDX_W-1:0]       vertex_count,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             mode,
  input  logic [VTX_W-1:0]       src_vertex,
  input  logic [VTX_W-1:0]       dst_vertex,
  input  logic [WEIGHT_BITS-1:0] edge_weight,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [SLOT_W-1:0]      slot,
  output logic [VTX_W-1:0]       row_index,
  output logic [WEIGHT_BITS-1:0] weight_out,
  output logic [CNT_W-1:0]       offset_value,
  output logic                   error
);

  logic [IDX_W-1:0] vcount;
  cmd_t             cmd;
  status_t          status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VTX_LIMIT;
    end else if (cfg_valid) begin
      vcount <= vertex_count;
    end
  end

  coo2csc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  coo2csc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .vertex_count (vcount),
    .mode         (mode),
    .src_vertex   (src_vertex),
    .dst_vertex   (dst_vertex),
    .edge_weight  (edge_weight),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .slot         (slot),
    .row_index    (row_index),
    .weight_out   (weight_out),
    .offset_value (offset_value),
    .error        (error)
  );

endmodule
